FILE: rtl/jtp_pkg.sv
// shared types, constants and register codes for the joint profile generator
package jtp_pkg;

	localparam int JOINTS = 6;
	localparam int POS_W  = 32;
	localparam int ERR_W  = POS_W + 1;
	localparam int ACC_W  = 28;
	localparam int VEL_W  = ACC_W + 1;
	localparam int NV_W   = ACC_W + 2;
	localparam int MRG_W  = 16;
	localparam int SEL_W  = 3;
	localparam int SQ_W   = 2 * ACC_W;
	localparam int LP_W   = SQ_W + MRG_W;
	localparam int RP_W   = ACC_W + ERR_W;
	localparam int CMP_W  = RP_W + 13;
	localparam int IDX_W  = 3;

	localparam logic [1:0] OP_FEEDBACK = 2'd0;
	localparam logic [1:0] OP_COMMAND  = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	localparam logic [IDX_W-1:0] REG_ACCEL       = 3'd0;
	localparam logic [IDX_W-1:0] REG_ACCEL_SENS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_STEP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_TOLERANCE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MARGIN      = 3'd4;
	localparam logic [IDX_W-1:0] REG_MARGIN_SENS = 3'd5;
	localparam logic [IDX_W-1:0] REG_SENS_JOINT  = 3'd6;

	localparam logic [ACC_W-1:0] RST_ACCEL       = 28'd187403;
	localparam logic [ACC_W-1:0] RST_ACCEL_SENS  = 28'd62468;
	localparam logic [ACC_W-1:0] RST_MAX_STEP    = 28'd5622099;
	localparam logic [ACC_W-1:0] RST_TOLERANCE   = 28'd26844;
	localparam logic [MRG_W-1:0] RST_MARGIN      = 16'd7373;
	localparam logic [MRG_W-1:0] RST_MARGIN_SENS = 16'd20480;
	localparam logic [SEL_W-1:0] RST_SENS_JOINT  = 3'd1;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [VEL_W-1:0] vel_t;

	typedef struct packed {
		logic [ACC_W-1:0] accel;
		logic [ACC_W-1:0] accel_sens;
		logic [ACC_W-1:0] max_step;
		logic [ACC_W-1:0] tolerance;
		logic [MRG_W-1:0] margin;
		logic [MRG_W-1:0] margin_sens;
	} cfg_t;

	typedef struct packed {
		logic load_fb;
		logic load_tgt;
		logic start;
	} lane_ctl_t;

endpackage

FILE: rtl/jtp_if.sv
// request, result and configuration channel interfaces
interface jtp_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               op;
	logic signed [jtp_pkg::POS_W-1:0] pos_0;
	logic signed [jtp_pkg::POS_W-1:0] pos_1;
	logic signed [jtp_pkg::POS_W-1:0] pos_2;
	logic signed [jtp_pkg::POS_W-1:0] pos_3;
	logic signed [jtp_pkg::POS_W-1:0] pos_4;
	logic signed [jtp_pkg::POS_W-1:0] pos_5;
	modport source (output valid, op, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5, input ready);
	modport sink (input valid, op, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5, output ready);
endinterface

interface jtp_rsp_if;
	logic                     valid;
	logic                     ready;
	logic signed [jtp_pkg::POS_W-1:0] cmd_0;
	logic signed [jtp_pkg::POS_W-1:0] cmd_1;
	logic signed [jtp_pkg::POS_W-1:0] cmd_2;
	logic signed [jtp_pkg::POS_W-1:0] cmd_3;
	logic signed [jtp_pkg::POS_W-1:0] cmd_4;
	logic signed [jtp_pkg::POS_W-1:0] cmd_5;
	logic                     all_at_target;
	modport source (output valid, cmd_0, cmd_1, cmd_2, cmd_3, cmd_4, cmd_5, all_at_target,
		input ready);
	modport sink (input valid, cmd_0, cmd_1, cmd_2, cmd_3, cmd_4, cmd_5, all_at_target,
		output ready);
endinterface

interface jtp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [jtp_pkg::IDX_W-1:0]      index;
	logic [jtp_pkg::ACC_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/jtp_lane.sv
// one joint: state, braking test pipeline and profile step
module jtp_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jtp_pkg::cfg_t        cfg,
	input  logic                 sens,
	input  jtp_pkg::lane_ctl_t   ctl,
	input  jtp_pkg::pos_t        pos_in,
	output jtp_pkg::pos_t        cmd,
	output logic                 at_tgt,
	output logic                 done
);
	localparam int PW = jtp_pkg::POS_W;
	localparam int EW = jtp_pkg::ERR_W;
	localparam int AW = jtp_pkg::ACC_W;
	localparam int VW = jtp_pkg::VEL_W;
	localparam int NW = jtp_pkg::NV_W;

	jtp_pkg::pos_t pos_q, tgt_q;
	jtp_pkg::vel_t vel_q;

	logic signed [EW-1:0] err;
	logic [EW-1:0] aerr;
	logic signed [VW-1:0] vneg_val;
	logic [AW-1:0] av;
	logic [jtp_pkg::SQ_W-1:0] sq;
	logic [jtp_pkg::RP_W-1:0] rp;

	logic v_s1, v_s2, v_s3, done_q, at_q;
	logic [jtp_pkg::SQ_W-1:0] sq_s1;
	logic [jtp_pkg::RP_W-1:0] rp_s1, rp_s2;
	logic [jtp_pkg::LP_W-1:0] lp_s2;
	logic tol_s1, tol_s2, tol_s3;
	logic dpos_s1, dpos_s2, dpos_s3;
	logic dneg_s1, dneg_s2, dneg_s3;
	logic near_s3;

	always_comb begin
		err = $signed({tgt_q[PW-1], tgt_q}) - $signed({pos_q[PW-1], pos_q});
		aerr = err[EW-1] ? EW'(-err) : EW'(err);
		vneg_val = -vel_q;
		av = vel_q[VW-1] ? vneg_val[AW-1:0] : vel_q[AW-1:0];
		sq = av * av;
		rp = cfg.accel * aerr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: error, squared speed, accel times error
	always_ff @(posedge clk) begin
		sq_s1   <= sq;
		rp_s1   <= rp;
		tol_s1  <= aerr < {{(EW-AW){1'b0}}, cfg.tolerance};
		dpos_s1 <= !err[EW-1] && (err != '0);
		dneg_s1 <= err[EW-1];
	end

	// stage 2: apply margin
	always_ff @(posedge clk) begin
		lp_s2   <= sq_s1 * (sens ? cfg.margin_sens : cfg.margin);
		rp_s2   <= rp_s1;
		tol_s2  <= tol_s1;
		dpos_s2 <= dpos_s1;
		dneg_s2 <= dneg_s1;
	end

	// stage 3: stopping distance compare
	always_ff @(posedge clk) begin
		near_s3 <= (cfg.accel != '0) &&
			({{(jtp_pkg::CMP_W-jtp_pkg::LP_W){1'b0}}, lp_s2} >= {rp_s2, 13'b0});
		tol_s3  <= tol_s2;
		dpos_s3 <= dpos_s2;
		dneg_s3 <= dneg_s2;
	end

	logic vpos, vneg, same_dir, opp, brake;
	logic signed [NW-1:0] v30, a30, s30, l30, nv;
	logic signed [PW:0] tent, tgt33;
	logic over;
	jtp_pkg::pos_t sat;

	always_comb begin
		vpos = !vel_q[VW-1] && (vel_q != '0);
		vneg = vel_q[VW-1];
		same_dir = (vpos && dpos_s3) || (vneg && dneg_s3);
		opp = (vpos && dneg_s3) || (vneg && dpos_s3);
		brake = same_dir ? near_s3 : opp;
		v30 = NW'(vel_q);
		a30 = $signed({2'b0, cfg.accel});
		s30 = $signed({2'b0, sens ? cfg.accel_sens : cfg.accel});
		l30 = $signed({2'b0, cfg.max_step});
		if (brake) begin
			nv = vpos ? v30 - a30 : v30 + a30;
			if (same_dir && ((vpos && nv <= 0) || (vneg && nv >= 0)))
				nv = '0;
		end else if (dpos_s3) begin
			nv = v30 + s30;
		end else if (dneg_s3) begin
			nv = v30 - s30;
		end else begin
			nv = v30;
		end
		if (nv > l30)
			nv = l30;
		if (nv < -l30)
			nv = -l30;
		tent = $signed({pos_q[PW-1], pos_q}) + (PW+1)'(nv);
		tgt33 = $signed({tgt_q[PW-1], tgt_q});
		over = (dpos_s3 && tent > tgt33) || (dneg_s3 && tent < tgt33);
		if (tent[PW] != tent[PW-1])
			sat = tent[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		else
			sat = tent[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tgt_q  <= '0;
			vel_q  <= '0;
			done_q <= 1'b0;
			at_q   <= 1'b0;
		end else begin
			done_q <= v_s3;
			if (ctl.load_fb) begin
				pos_q <= pos_in;
				tgt_q <= pos_in;
				vel_q <= '0;
			end else if (ctl.load_tgt) begin
				tgt_q <= pos_in;
			end else if (v_s3) begin
				at_q <= tol_s3;
				if (tol_s3 || over) begin
					pos_q <= tgt_q;
					vel_q <= '0;
				end else begin
					pos_q <= sat;
					vel_q <= nv[VW-1:0];
				end
			end
		end
	end

	assign cmd    = pos_q;
	assign at_tgt = at_q;
	assign done   = done_q;
endmodule

FILE: rtl/jtp_merge.sv
// merges lane results into the result register
module jtp_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 done,
	input  jtp_pkg::pos_t        cmd [jtp_pkg::JOINTS],
	input  logic [jtp_pkg::JOINTS-1:0] at_tgt,
	jtp_rsp_if.source            rsp
);
	logic valid_q, all_q;
	jtp_pkg::pos_t cmd_q [jtp_pkg::JOINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (done)
			valid_q <= 1'b1;
		else if (rsp.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			cmd_q <= cmd;
			all_q <= &at_tgt;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.cmd_0         = cmd_q[0];
	assign rsp.cmd_1         = cmd_q[1];
	assign rsp.cmd_2         = cmd_q[2];
	assign rsp.cmd_3         = cmd_q[3];
	assign rsp.cmd_4         = cmd_q[4];
	assign rsp.cmd_5         = cmd_q[5];
	assign rsp.all_at_target = all_q;
endmodule

FILE: rtl/joint_trapezoid_profile_generator.sv
// top level: six-joint trapezoidal profile generator
// feedback and command requests give no result
// a tick request passes three lane stages
// (squares, margin product, stopping compare) and a state update, then the result register raises rsp.valid
// one request at a time: a new request is taken once no tick is in flight and the result register is empty
// reset clears all joint state and the initialized flag, registers go to defaults
module joint_trapezoid_profile_generator (
	input  logic        clk,
	input  logic        arst_n,
	jtp_req_if.sink     req,
	jtp_rsp_if.source   rsp,
	jtp_cfg_if.sink     cfg
);
	jtp_pkg::cfg_t cfg_q;
	logic [jtp_pkg::SEL_W-1:0] sens_q;
	logic init_q, busy_q, acc;
	jtp_pkg::lane_ctl_t ctl;
	jtp_pkg::pos_t pos_in [jtp_pkg::JOINTS];
	jtp_pkg::pos_t cmd [jtp_pkg::JOINTS];
	logic [jtp_pkg::JOINTS-1:0] at_tgt, done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel       <= jtp_pkg::RST_ACCEL;
			cfg_q.accel_sens  <= jtp_pkg::RST_ACCEL_SENS;
			cfg_q.max_step    <= jtp_pkg::RST_MAX_STEP;
			cfg_q.tolerance   <= jtp_pkg::RST_TOLERANCE;
			cfg_q.margin      <= jtp_pkg::RST_MARGIN;
			cfg_q.margin_sens <= jtp_pkg::RST_MARGIN_SENS;
			sens_q            <= jtp_pkg::RST_SENS_JOINT;
		end else if (cfg.valid) begin
			case (cfg.index)
				jtp_pkg::REG_ACCEL:       cfg_q.accel       <= cfg.data;
				jtp_pkg::REG_ACCEL_SENS:  cfg_q.accel_sens  <= cfg.data;
				jtp_pkg::REG_MAX_STEP:    cfg_q.max_step    <= cfg.data;
				jtp_pkg::REG_TOLERANCE:   cfg_q.tolerance   <= cfg.data;
				jtp_pkg::REG_MARGIN:      cfg_q.margin      <= cfg.data[jtp_pkg::MRG_W-1:0];
				jtp_pkg::REG_MARGIN_SENS: cfg_q.margin_sens <= cfg.data[jtp_pkg::MRG_W-1:0];
				jtp_pkg::REG_SENS_JOINT:  sens_q            <= cfg.data[jtp_pkg::SEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = !busy_q && !rsp.valid;
	assign acc = req.valid && req.ready;

	always_comb begin
		ctl.load_fb  = acc && (req.op == jtp_pkg::OP_FEEDBACK) && !init_q;
		ctl.load_tgt = acc && (req.op == jtp_pkg::OP_COMMAND) && init_q;
		ctl.start    = acc && (req.op == jtp_pkg::OP_TICK) && init_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (ctl.load_fb)
				init_q <= 1'b1;
			if (ctl.start)
				busy_q <= 1'b1;
			else if (done[0])
				busy_q <= 1'b0;
		end
	end

	assign pos_in[0] = req.pos_0;
	assign pos_in[1] = req.pos_1;
	assign pos_in[2] = req.pos_2;
	assign pos_in[3] = req.pos_3;
	assign pos_in[4] = req.pos_4;
	assign pos_in[5] = req.pos_5;

	for (genvar i = 0; i < jtp_pkg::JOINTS; i++) begin : g_lane
		jtp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.sens   (sens_q == jtp_pkg::SEL_W'(i)),
			.ctl    (ctl),
			.pos_in (pos_in[i]),
			.cmd    (cmd[i]),
			.at_tgt (at_tgt[i]),
			.done   (done[i])
		);
	end

	jtp_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.done   (done[0]),
		.cmd    (cmd),
		.at_tgt (at_tgt),
		.rsp    (rsp)
	);

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready) else $error("request taken while tick in flight");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done[0] |-> busy_q) else $error("lane finished without a tick");
	a_rsp_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(done[0])) else $error("result without lane finish");
	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |=> init_q) else $error("initialized flag dropped");
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done == '0 || done == '1) else $error("lanes out of step");
endmodule

FILE: dv/joint_trapezoid_profile_generator_test.sv
// self-checking bench for the joint trapezoid profile generator
module joint_trapezoid_profile_generator_test;
	import jtp_pkg::*;

	typedef struct {
		pos_t cmd[JOINTS];
		logic all;
	} cmd_set_t;

	typedef struct {
		logic [1:0] op;
		pos_t p[JOINTS];
		bit known;
		bit k_all;
	} stim_row_t;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam pos_t PMAX = 32'sh7FFFFFFF;
	localparam pos_t PMIN = 32'sh80000000;
	localparam logic [ACC_W-1:0] ACC_MAX = 28'hFFFFFFF;
	localparam int unsigned LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n;

	jtp_req_if req_ch ();
	jtp_rsp_if rsp_ch ();
	jtp_cfg_if cfg_ch ();

	joint_trapezoid_profile_generator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	longint unsigned m_accel, m_accel_sens, m_max_step, m_tol, m_margin, m_margin_sens;
	int unsigned m_sens;
	longint m_tgt[JOINTS];
	longint m_cmd[JOINTS];
	longint m_vel[JOINTS];
	bit m_init;

	cmd_set_t pending_cmds[$];
	int unsigned fails = 0;
	int unsigned cycles = 0;
	int burst_left = 4;
	int unsigned stall_mode = 0;

	function automatic bit stop_needed(longint v, longint unsigned aerr, longint unsigned mrg);
		logic [127:0] lhs, rhs;
		longint unsigned av;
		av = (v < 0) ? longint'(-v) : longint'(v);
		if (m_accel == 0)
			return 1'b0;
		lhs = 128'(av) * 128'(av) * 128'(mrg);
		rhs = 128'(m_accel) * 128'(aerr) * 128'(8192);
		return lhs >= rhs;
	endfunction

	function automatic cmd_set_t advance_joints();
		cmd_set_t r;
		longint err, v, nv, lim, tent;
		longint unsigned aerr;
		int dir, sv;
		bit sens, brake;
		r.all = 1'b1;
		for (int i = 0; i < JOINTS; i++) begin
			err = m_tgt[i] - m_cmd[i];
			aerr = (err < 0) ? longint'(-err) : longint'(err);
			v = m_vel[i];
			sens = (i == m_sens);
			dir = (err > 0) - (err < 0);
			sv = (v > 0) - (v < 0);
			brake = 1'b0;
			if (aerr < m_tol) begin
				m_vel[i] = 0;
				m_cmd[i] = m_tgt[i];
			end else begin
				r.all = 1'b0;
				if (dir != 0) begin
					if (sv == dir)
						brake = stop_needed(v, aerr, sens ? m_margin_sens : m_margin);
					else if (sv != 0)
						brake = 1'b1;
				end
				if (brake) begin
					nv = v - sv * longint'(m_accel);
					if (sv == dir && ((nv > 0) - (nv < 0)) != sv)
						nv = 0;
				end else begin
					nv = v + dir * longint'(sens ? m_accel_sens : m_accel);
				end
				lim = longint'(m_max_step);
				if (nv > lim)
					nv = lim;
				if (nv < -lim)
					nv = -lim;
				tent = m_cmd[i] + nv;
				if ((dir > 0 && tent > m_tgt[i]) || (dir < 0 && tent < m_tgt[i])) begin
					m_cmd[i] = m_tgt[i];
					m_vel[i] = 0;
				end else begin
					if (tent > longint'(PMAX))
						tent = longint'(PMAX);
					if (tent < longint'(PMIN))
						tent = longint'(PMIN);
					m_cmd[i] = tent;
					m_vel[i] = nv;
				end
			end
		end
		for (int i = 0; i < JOINTS; i++)
			r.cmd[i] = pos_t'(m_cmd[i]);
		return r;
	endfunction

	// update predictor for one accepted request, queue the tick result if any
	function automatic void apply_request(stim_row_t s);
		cmd_set_t r;
		if (s.op == OP_FEEDBACK && !m_init) begin
			for (int i = 0; i < JOINTS; i++) begin
				m_cmd[i] = s.p[i];
				m_tgt[i] = s.p[i];
				m_vel[i] = 0;
			end
			m_init = 1'b1;
		end else if (s.op == OP_COMMAND && m_init) begin
			for (int i = 0; i < JOINTS; i++)
				m_tgt[i] = s.p[i];
		end else if (s.op == OP_TICK && m_init) begin
			r = advance_joints();
			if (s.known) begin
				r.cmd = s.p;
				r.all = s.k_all;
			end
			pending_cmds.push_back(r);
		end
	endfunction

	function automatic void set_reg(logic [IDX_W-1:0] idx, logic [ACC_W-1:0] d);
		case (idx)
			REG_ACCEL:       m_accel = d;
			REG_ACCEL_SENS:  m_accel_sens = d;
			REG_MAX_STEP:    m_max_step = d;
			REG_TOLERANCE:   m_tol = d;
			REG_MARGIN:      m_margin = d[MRG_W-1:0];
			REG_MARGIN_SENS: m_margin_sens = d[MRG_W-1:0];
			REG_SENS_JOINT:  m_sens = d[SEL_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic issue_request(stim_row_t s);
		req_ch.valid <= 1'b1;
		req_ch.op <= s.op;
		req_ch.pos_0 <= s.p[0];
		req_ch.pos_1 <= s.p[1];
		req_ch.pos_2 <= s.p[2];
		req_ch.pos_3 <= s.p[3];
		req_ch.pos_4 <= s.p[4];
		req_ch.pos_5 <= s.p[5];
		do @(posedge clk); while (!req_ch.ready);
		apply_request(s);
		burst_left--;
		if (burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
	endtask

	// leaves valid high so back-to-back writes need no gap
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [ACC_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		set_reg(idx, d);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic stim_row_t random_row();
		stim_row_t s;
		int unsigned r, sh;
		longint off, t;
		r = $urandom_range(0, 99);
		s.known = 1'b0;
		s.k_all = 1'b0;
		for (int i = 0; i < JOINTS; i++)
			s.p[i] = pos_t'($urandom);
		if (r < 50) begin
			s.op = OP_TICK;
		end else if (r < 82) begin
			s.op = OP_COMMAND;
			for (int i = 0; i < JOINTS; i++) begin
				sh = $urandom_range(0, 30);
				off = longint'($urandom) & ((64'd1 << sh) - 1);
				if ($urandom_range(0, 1))
					off = -off;
				t = m_cmd[i] + off;
				if ($urandom_range(0, 7) == 0)
					t = m_cmd[i];
				if (t > longint'(PMAX))
					t = longint'(PMAX);
				if (t < longint'(PMIN))
					t = longint'(PMIN);
				s.p[i] = pos_t'(t);
			end
		end else if (r < 92) begin
			s.op = OP_COMMAND;
			for (int i = 0; i < JOINTS; i++)
				if ($urandom_range(0, 3) == 0)
					s.p[i] = $urandom_range(0, 1) ? PMAX : PMIN;
		end else if (r < 96) begin
			s.op = OP_FEEDBACK;
		end else begin
			s.op = OP_UNUSED;
		end
		return s;
	endfunction

	// receiver with a stall pattern that is redrawn at random from three modes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 64 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 9) > 2);
			default: rsp_ch.ready <= ($urandom_range(0, 9) > 6);
		endcase
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			cmd_set_t e;
			pos_t got[JOINTS];
			got = '{rsp_ch.cmd_0, rsp_ch.cmd_1, rsp_ch.cmd_2,
				rsp_ch.cmd_3, rsp_ch.cmd_4, rsp_ch.cmd_5};
			if (pending_cmds.size() == 0) begin
				$error("unexpected result");
				fails++;
			end else begin
				e = pending_cmds.pop_front();
				for (int i = 0; i < JOINTS; i++)
					if (got[i] !== e.cmd[i]) begin
						$error("cmd_%0d expected %0d actual %0d", i, e.cmd[i], got[i]);
						fails++;
					end
				if (rsp_ch.all_at_target !== e.all) begin
					$error("all_at_target expected %0d actual %0d", e.all, rsp_ch.all_at_target);
					fails++;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("joint_trapezoid_profile_generator: mismatch");
			$finish;
		end
	end

	initial begin
		stim_row_t plan[$];
		stim_row_t s;
		pos_t ext[JOINTS];
		pos_t tg[JOINTS];
		pos_t z[JOINTS];
		int n;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_FEEDBACK;
		req_ch.pos_0 <= '0;
		req_ch.pos_1 <= '0;
		req_ch.pos_2 <= '0;
		req_ch.pos_3 <= '0;
		req_ch.pos_4 <= '0;
		req_ch.pos_5 <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_ACCEL;
		cfg_ch.data <= '0;
		m_accel = RST_ACCEL;
		m_accel_sens = RST_ACCEL_SENS;
		m_max_step = RST_MAX_STEP;
		m_tol = RST_TOLERANCE;
		m_margin = RST_MARGIN;
		m_margin_sens = RST_MARGIN_SENS;
		m_sens = RST_SENS_JOINT;
		m_init = 1'b0;
		for (int i = 0; i < JOINTS; i++) begin
			m_tgt[i] = 0;
			m_cmd[i] = 0;
			m_vel[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		ext = '{PMAX, PMIN, 32'sd0, -32'sd1, 32'sd1, 32'sh55555555};
		tg = '{PMIN, PMAX, 32'sd26843, 32'sd26843, 32'sd1, 32'shAAAAAAAA};
		z = '{default: 32'sd0};
		plan.push_back('{OP_TICK, z, 1'b0, 1'b0});
		plan.push_back('{OP_COMMAND, tg, 1'b0, 1'b0});
		plan.push_back('{OP_UNUSED, ext, 1'b0, 1'b0});
		plan.push_back('{OP_FEEDBACK, ext, 1'b0, 1'b0});
		plan.push_back('{OP_TICK, ext, 1'b1, 1'b1});
		plan.push_back('{OP_FEEDBACK, z, 1'b0, 1'b0});
		plan.push_back('{OP_TICK, ext, 1'b1, 1'b1});
		plan.push_back('{OP_UNUSED, z, 1'b0, 1'b0});
		plan.push_back('{OP_COMMAND, tg, 1'b0, 1'b0});
		repeat (12) plan.push_back('{OP_TICK, z, 1'b0, 1'b0});
		plan.push_back('{OP_COMMAND, ext, 1'b0, 1'b0});
		repeat (3) plan.push_back('{OP_TICK, z, 1'b0, 1'b0});
		foreach (plan[k])
			issue_request(plan[k]);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: ;
				1: begin
					write_reg(REG_ACCEL, ACC_MAX);
					write_reg(REG_ACCEL_SENS, ACC_MAX);
					write_reg(REG_MAX_STEP, ACC_MAX);
					write_reg(REG_TOLERANCE, '0);
					write_reg(REG_MARGIN, 28'hFFFF);
					write_reg(REG_MARGIN_SENS, 28'hFFFF);
					write_reg(REG_SENS_JOINT, 28'd0);
				end
				2: begin
					write_reg(REG_ACCEL, '0);
					write_reg(REG_ACCEL_SENS, ACC_W'($urandom_range(1, 1 << 22)));
					write_reg(REG_MAX_STEP, ACC_W'($urandom_range(1, 1 << 24)));
					write_reg(REG_TOLERANCE, '0);
					write_reg(REG_MARGIN, '0);
					write_reg(REG_MARGIN_SENS, '0);
					write_reg(REG_SENS_JOINT, 28'd6);
				end
				3: begin
					write_reg(REG_ACCEL, ACC_W'($urandom_range(1, 1 << 22)));
					write_reg(REG_ACCEL_SENS, ACC_W'($urandom_range(1, 1 << 22)));
					write_reg(REG_MAX_STEP, ACC_W'($urandom_range(1 << 16, 1 << 26)));
					write_reg(REG_TOLERANCE, ACC_W'($urandom_range(0, 1 << 18)));
					write_reg(REG_MARGIN, ACC_W'($urandom));
					write_reg(REG_MARGIN_SENS, ACC_W'($urandom));
					write_reg(REG_SENS_JOINT, ACC_W'($urandom_range(0, 5)));
				end
				4: begin
					write_reg(REG_ACCEL, ACC_W'($urandom));
					write_reg(REG_ACCEL_SENS, ACC_W'($urandom));
					write_reg(REG_MAX_STEP, ACC_W'($urandom));
					write_reg(REG_TOLERANCE, ACC_W'($urandom_range(0, 1 << 20)));
					write_reg(REG_MARGIN, ACC_W'($urandom));
					write_reg(REG_MARGIN_SENS, ACC_W'($urandom));
					write_reg(REG_SENS_JOINT, 28'd7);
				end
				default: begin
					write_reg(REG_ACCEL, RST_ACCEL);
					write_reg(REG_ACCEL_SENS, RST_ACCEL_SENS);
					write_reg(REG_MAX_STEP, RST_MAX_STEP);
					write_reg(REG_TOLERANCE, RST_TOLERANCE);
					write_reg(REG_MARGIN, ACC_W'(RST_MARGIN));
					write_reg(REG_MARGIN_SENS, ACC_W'(RST_MARGIN_SENS));
					write_reg(REG_SENS_JOINT, ACC_W'($urandom_range(0, 5)));
				end
			endcase
			cfg_ch.valid <= 1'b0;
			n = 0;
			while (n < 125) begin
				s = random_row();
				if (s.op == OP_COMMAND || s.op == OP_TICK)
					n++;
				issue_request(s);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fails == 0 && pending_cmds.size() == 0)
			$display("joint_trapezoid_profile_generator: match");
		else
			$display("joint_trapezoid_profile_generator: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/jtp_pkg.sv
rtl/jtp_if.sv
rtl/jtp_lane.sv
rtl/jtp_merge.sv
rtl/joint_trapezoid_profile_generator.sv
dv/joint_trapezoid_profile_generator_test.sv
